// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ttip_pkg.sv
// Package with beat types, widths and constants of the text to integer parser.
package ttip_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned BASE_W  = 6;

	// Configuration register indexes.
	localparam logic CFG_RADIX    = 1'b0;
	localparam logic CFG_UNSIGNED = 1'b1;

	localparam logic [BASE_W-1:0] RADIX_RESET = BASE_W'(10);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              first;
	} char_beat_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] consumed;
	} result_beat_t;

endpackage

// File: rtl/text_to_integer_parser.sv
// Streaming string to integer parser in the style of strtol and strtoul.
// Pipeline: an accepted character beat is decoded from the input register, and a result that
// it ends is loaded into the result register, which drives res_valid. Throughput: one character
// per cycle unless res_stall holds a result; the base multiply-accumulate is the long path.
// Reset: arst_n clears the pipeline, selects radix 10 and signed mode, and leaves the parser
// waiting for a beat with the first flag.
module text_to_integer_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	// Character input channel.
	input  logic                     char_valid,
	output logic                     char_stall,
	input  ttip_pkg::char_beat_t     char_beat,
	// Result output channel.
	output logic                     res_valid,
	input  logic                     res_stall,
	output ttip_pkg::result_beat_t   res_beat,
	// Configuration write channel.
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [5:0]               cfg_data
);
	import ttip_pkg::*;

	// Parse phase. DONE ignores everything until a beat that carries the first flag.
	typedef enum logic [2:0] {
		PH_DONE,
		PH_SPACE,
		PH_START,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Digit weight of a character; the top bit flags a valid digit.
	function automatic logic [BASE_W:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [BASE_W:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, BASE_W'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = {1'b1, BASE_W'(c - 8'h61 + 8'd10)};
		end else if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b1, BASE_W'(c - 8'h41 + 8'd10)};
		end
		return r;
	endfunction

	// Configuration registers.
	logic [BASE_W-1:0]  radix_q;
	logic               unsigned_q;

	// Input register: the accepted beat waits here while it is decoded.
	logic               valid_s1;
	char_beat_t         beat_s1;

	// Parse state.
	phase_t             phase_q;
	logic [VALUE_W-1:0] acc_q;
	logic               neg_q;
	logic [BASE_W-1:0]  base_q;
	logic [COUNT_W-1:0] cnt_q;

	// Result register.
	logic               res_valid_q;
	result_beat_t       res_q;

	// Next-state values computed from the beat in the input register.
	phase_t             ph_n;
	logic [VALUE_W-1:0] acc_n;
	logic               neg_n;
	logic [BASE_W-1:0]  base_n;
	logic [COUNT_W-1:0] cnt_n;
	logic [VALUE_W-1:0] value_n;
	logic               handled;
	logic               take;
	logic               emit;
	logic [BASE_W:0]    dig;
	logic               is_space;
	logic               is_sign;
	logic               is_x;
	logic               go_s1;
	logic               step;

	// The decode stage moves whenever the result register is empty or being drained. The input
	// register and the result register are the buffers between the sides, so a character is refused
	// only while a finished result is held up downstream and another character is already waiting.
	assign go_s1      = !res_valid_q || !res_stall;
	assign step       = valid_s1 && go_s1;
	assign char_stall = valid_s1 && !go_s1;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res_beat   = res_q;

	assign dig      = digit_of(beat_s1.ch);
	assign is_space = beat_s1.ch inside {8'h20, [8'h09:8'h0D]};
	assign is_sign  = (beat_s1.ch == 8'h2B) || (beat_s1.ch == 8'h2D && !unsigned_q);
	assign is_x     = (beat_s1.ch == 8'h78) || (beat_s1.ch == 8'h58);

	// One character of the parse. The phases fall through in order, just as a character that
	// is not whitespace or sign is tried next as a prefix zero and then as a digit.
	always_comb begin
		ph_n    = phase_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		base_n  = base_q;
		cnt_n   = cnt_q;
		handled = 1'b0;
		take    = 1'b0;
		emit    = 1'b0;
		value_n = '0;

		// The first flag restarts the parse even in the middle of a string, and samples radix.
		if (beat_s1.first) begin
			ph_n   = PH_SPACE;
			acc_n  = '0;
			neg_n  = 1'b0;
			base_n = radix_q;
			cnt_n  = '0;
		end

		if (ph_n == PH_SPACE) begin
			if (is_space) begin
				take    = 1'b1;
				handled = 1'b1;
			end else if (is_sign) begin
				neg_n   = (beat_s1.ch == 8'h2D);
				take    = 1'b1;
				handled = 1'b1;
				ph_n    = PH_START;
			end else begin
				ph_n = PH_START;
			end
		end

		if (!handled && ph_n == PH_START) begin
			// A leading zero may open a hex prefix when the base is automatic or sixteen.
			if ((base_n == '0 || base_n == BASE_W'(16)) && beat_s1.ch == 8'h30) begin
				acc_n   = '0;
				take    = 1'b1;
				handled = 1'b1;
				ph_n    = PH_ZERO;
			end else begin
				if (base_n == '0) begin
					base_n = BASE_W'(10);
				end
				ph_n = PH_DIGITS;
			end
		end else if (!handled && ph_n == PH_ZERO) begin
			if (is_x) begin
				base_n  = BASE_W'(16);
				take    = 1'b1;
				handled = 1'b1;
				ph_n    = PH_DIGITS;
			end else begin
				// The zero was a plain digit; in automatic mode it means octal.
				if (base_n == '0) begin
					base_n = BASE_W'(8);
				end
				ph_n = PH_DIGITS;
			end
		end

		if (!handled && ph_n == PH_DIGITS) begin
			if (dig[BASE_W] && dig[BASE_W-1:0] < base_n) begin
				acc_n = VALUE_W'(acc_n * VALUE_W'(base_n)) + VALUE_W'(dig[BASE_W-1:0]);
				take  = 1'b1;
			end else begin
				// The stopping character is not counted and ends the string.
				emit    = 1'b1;
				value_n = (neg_n && !unsigned_q) ? VALUE_W'(-acc_n) : acc_n;
				ph_n    = PH_DONE;
			end
		end

		if (take && cnt_n != COUNT_MAX) begin
			cnt_n = cnt_n + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			unsigned_q  <= 1'b0;
			valid_s1    <= 1'b0;
			phase_q     <= PH_DONE;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			base_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RADIX:    radix_q    <= cfg_data;
					CFG_UNSIGNED: unsigned_q <= cfg_data[0];
					default:      ;
				endcase
			end

			if (char_valid && !char_stall) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end

			if (step) begin
				phase_q <= ph_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				base_q  <= base_n;
				cnt_q   <= cnt_n;
			end

			if (step && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers load without reset.
	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			beat_s1 <= char_beat;
		end
		if (step && emit) begin
			res_q.value    <= value_n;
			res_q.consumed <= cnt_n;
		end
	end

endmodule

// File: rtl/ttip_checker.sv
// Port-level checker of the text to integer parser and its bind.
`include "assert_macros.svh"

module ttip_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   char_valid,
	input logic                   char_stall,
	input ttip_pkg::char_beat_t   char_beat,
	input logic                   res_valid,
	input logic                   res_stall,
	input ttip_pkg::result_beat_t res_beat,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic                   cfg_index,
	input logic [5:0]             cfg_data
);
	import ttip_pkg::*;

	// A result that waits downstream keeps its value.
	`ASSERT_CLK(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid && $stable(res_beat), "result beat changed while stalled")

	// The input side backs up only when a result is held up at the output.
	`ASSERT_ALWAYS(a_stall_cause, clk, char_stall |-> (res_valid && res_stall), "input stalled without output back-pressure")

	// A fresh result traces back to a character beat accepted earlier at the input.
	`ASSERT_CLK(a_res_source, clk, arst_n, $rose(res_valid) |-> $past(char_valid && !char_stall, 2), "result without a matching character beat")

	// Configuration writes are never refused.
	`ASSERT_CLK(a_cfg_ready, clk, arst_n, cfg_ready, "configuration port not ready")

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (.*);

// File: tb/text_to_integer_parser_tb.sv
// Self-checking testbench of the streaming text to integer parser.
module text_to_integer_parser_tb;
	import ttip_pkg::*;

	// The block answers through its input and result registers. These drain cycles are waited
	// out before registers change and before the run ends.
	localparam int unsigned DRAIN_CYCLES = 6;
	// Length of the one long receiver hold-off. The block is meant to fill up and stall its
	// character input during it.
	localparam int unsigned HOLD_CYCLES = 100;
	localparam int unsigned PHASE_COUNT = 12;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam int unsigned PRINT_LIMIT = 200;

	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE   = " ";
	localparam logic [CHAR_W-1:0] CH_PLUS    = "+";
	localparam logic [CHAR_W-1:0] CH_MINUS   = "-";
	localparam logic [CHAR_W-1:0] CH_ZERO    = "0";
	localparam logic [CHAR_W-1:0] CH_LOWER_X = "x";
	localparam logic [CHAR_W-1:0] CH_UPPER_X = "X";
	localparam logic [CHAR_W-1:0] NOT_DIGIT  = 8'hFF;

	// Where the parse of the current string stands.
	typedef enum logic [2:0] {
		PS_DONE,
		PS_SPACE,
		PS_START,
		PS_ZERO,
		PS_DIGITS
	} parse_phase_t;

	logic clk;
	logic arst_n = 1'b0;

	logic         char_valid = 1'b0;
	logic         char_stall;
	char_beat_t   char_beat  = '0;
	logic         res_valid;
	logic         res_stall  = 1'b0;
	result_beat_t res_beat;
	logic         cfg_valid  = 1'b0;
	logic         cfg_ready;
	logic         cfg_index  = CFG_RADIX;
	logic [5:0]   cfg_data   = '0;

	text_to_integer_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_beat   (res_beat),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Characters waiting to be offered, and parse results that the block still owes us.
	char_beat_t   text_queue[$];
	result_beat_t predicted_numbers[$];
	result_beat_t number_head;
	int unsigned  queued_items = 0;
	int unsigned  error_count  = 0;

	// Pacing. Each side draws its wait per beat from 0 up to these limits; a limit of zero
	// gives a stretch with no idling at all.
	int unsigned  gap_max   = 0;
	int unsigned  stall_max = 0;
	int unsigned  char_gap  = 0;
	int unsigned  res_wait  = 0;
	logic         hold_req  = 1'b0;
	int unsigned  hold_left = 0;

	// Our own copy of the register file, updated on every completed write.
	logic [BASE_W-1:0]  radix_mirror    = RADIX_RESET;
	logic               unsigned_mirror = 1'b0;

	// Our own copy of the parser state.
	parse_phase_t       parse_state  = PS_DONE;
	logic [VALUE_W-1:0] acc_value    = '0;
	logic               acc_negative = 1'b0;
	logic [BASE_W-1:0]  acc_base     = '0;
	logic [COUNT_W-1:0] char_total   = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops results.
	initial begin
		#5000000;
		$display("** text_to_integer_parser: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (error_count < PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, what);
		error_count++;
	endtask

	// Weight of a character as a digit in any base up to 36, or all ones for anything else.
	function automatic logic [CHAR_W-1:0] digit_weight(input logic [CHAR_W-1:0] c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "a" && c <= "z")
			return c - "a" + 8'd10;
		if (c >= "A" && c <= "Z")
			return c - "A" + 8'd10;
		return NOT_DIGIT;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input int unsigned w, input bit upper);
		if (w < 10)
			return CH_ZERO + CHAR_W'(w);
		return (upper ? CH_UPPER_X - 8'd23 : CH_LOWER_X - 8'd23) + CHAR_W'(w - 10);
	endfunction

	task automatic count_char();
		if (char_total != {COUNT_W{1'b1}})
			char_total++;
	endtask

	// Advance the parse by one accepted character and queue the number it finishes, if any.
	task automatic parse_char(input char_beat_t beat);
		logic [CHAR_W-1:0]  c;
		logic [CHAR_W-1:0]  w;
		logic               taken;
		result_beat_t       number;

		c = beat.ch;
		taken = 1'b0;
		// A first flag restarts the parse wherever it stands; the base is sampled here.
		if (beat.first) begin
			parse_state  = PS_SPACE;
			acc_value    = '0;
			acc_negative = 1'b0;
			acc_base     = radix_mirror;
			char_total   = '0;
		end
		if (parse_state != PS_DONE) begin
			if (parse_state == PS_SPACE) begin
				if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
					count_char();
					taken = 1'b1;
				end else if (c == CH_PLUS || (c == CH_MINUS && !unsigned_mirror)) begin
					acc_negative = (c == CH_MINUS);
					count_char();
					parse_state = PS_START;
					taken = 1'b1;
				end else begin
					parse_state = PS_START;
				end
			end
			if (!taken && parse_state == PS_START) begin
				// A leading zero may open a hex prefix when the base is auto or 16.
				if ((acc_base == 0 || acc_base == 16) && c == CH_ZERO) begin
					acc_value = '0;
					count_char();
					parse_state = PS_ZERO;
					taken = 1'b1;
				end else begin
					if (acc_base == 0)
						acc_base = 6'd10;
					parse_state = PS_DIGITS;
				end
			end else if (!taken && parse_state == PS_ZERO) begin
				// The zero stays counted as a digit when no x follows it.
				if (c == CH_LOWER_X || c == CH_UPPER_X) begin
					acc_base = 6'd16;
					count_char();
					parse_state = PS_DIGITS;
					taken = 1'b1;
				end else begin
					if (acc_base == 0)
						acc_base = 6'd8;
					parse_state = PS_DIGITS;
				end
			end
			if (!taken) begin
				w = digit_weight(c);
				if (w < acc_base) begin
					acc_value = acc_value * VALUE_W'(acc_base) + VALUE_W'(w);
					count_char();
				end else begin
					// The stopping character ends the string and is not counted. The sign
					// mode is looked at here, so a change in mid-string counts at once.
					number.value    = (acc_negative && !unsigned_mirror) ? -acc_value : acc_value;
					number.consumed = char_total;
					predicted_numbers.push_back(number);
					parse_state = PS_DONE;
				end
			end
		end
	endtask

	// Character driver. A beat is taken at an edge with valid high and stall low; the
	// prediction is made right there, in the order of acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				parse_char(char_beat);
				char_gap = $urandom_range(gap_max);
			end
			// A stalled beat stays put; otherwise the next one goes out once the gap is over.
			if (!char_valid || !char_stall) begin
				if (char_gap == 0 && text_queue.size() != 0) begin
					char_beat  <= text_queue.pop_front();
					char_valid <= 1'b1;
				end else begin
					char_valid <= 1'b0;
					if (char_gap != 0)
						char_gap--;
				end
			end
		end
	end

	// Long hold-off of the receiver, counted here and merged into the stall by the monitor.
	always @(posedge clk) begin
		if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Result monitor. Every accepted result must match the oldest prediction field by field.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (predicted_numbers.size() == 0) begin
					report_mismatch($sformatf("result with none expected: value %h consumed %0d",
						res_beat.value, res_beat.consumed));
				end else begin
					number_head = predicted_numbers.pop_front();
					if (res_beat.value !== number_head.value)
						report_mismatch($sformatf("value %h, expected %h",
							res_beat.value, number_head.value));
					if (res_beat.consumed !== number_head.consumed)
						report_mismatch($sformatf("consumed %0d, expected %0d",
							res_beat.consumed, number_head.consumed));
				end
				res_wait = $urandom_range(stall_max);
			end
			if (res_wait != 0) begin
				res_stall <= 1'b1;
				res_wait--;
			end else begin
				res_stall <= (hold_left != 0);
			end
		end
	end

	task automatic push_char(input logic [CHAR_W-1:0] c, input logic first);
		char_beat_t beat;
		beat.ch    = c;
		beat.first = first;
		text_queue.push_back(beat);
		queued_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b0);
	endtask

	// One number string with random content: optional whitespace, sign, prefix, digits that
	// fit the base the parse is expected to use, then a NUL or a random character that may stop it.
	task automatic push_number();
		int unsigned limit;
		int unsigned pick;
		int unsigned n_digits;
		int unsigned k;
		logic        head;

		head = 1'b1;
		if ($urandom_range(2) == 0) begin
			repeat ($urandom_range(3, 1)) begin
				k = $urandom_range(5);
				push_char((k == 5) ? CH_SPACE : CHAR_W'(9 + k), head);
				head = 1'b0;
			end
		end
		pick = $urandom_range(3);
		if (pick == 1) begin
			push_char(CH_PLUS, head);
			head = 1'b0;
		end else if (pick == 2) begin
			push_char(CH_MINUS, head);
			head = 1'b0;
		end
		limit = 32'(radix_mirror);
		pick = $urandom_range(3);
		if (pick == 0) begin
			push_char(CH_ZERO, head);
			push_char($urandom_range(1) ? CH_UPPER_X : CH_LOWER_X, 1'b0);
			head = 1'b0;
			if (limit == 0)
				limit = 16;
		end else if (pick == 1) begin
			push_char(CH_ZERO, head);
			head = 1'b0;
			if (limit == 0)
				limit = 8;
		end
		if (limit == 0)
			limit = 10;
		if (limit > 36)
			limit = 36;
		// Now and then a long run of digits, so that the value can wrap.
		n_digits = ($urandom_range(3) == 0) ? $urandom_range(14) : $urandom_range(6);
		repeat (n_digits) begin
			push_char(digit_char($urandom_range(limit - 1), 1'($urandom_range(1))), head);
			head = 1'b0;
		end
		push_char($urandom_range(1) ? CH_NUL : CHAR_W'($urandom_range(255)), head);
	endtask

	// Arbitrary characters, now and then with the first flag.
	task automatic push_noise();
		repeat ($urandom_range(4, 1))
			push_char(CHAR_W'($urandom_range(255)), $urandom_range(7) == 0);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (text_queue.size() != 0 || char_valid || predicted_numbers.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [5:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (index == CFG_RADIX)
			radix_mirror = data;
		else
			unsigned_mirror = data[0];
	endtask

	task automatic set_pace(input int unsigned gap, input int unsigned stall);
		@(posedge clk);
		gap_max   <= gap;
		stall_max <= stall;
	endtask

	initial begin
		logic [5:0]  plan_radix;
		int unsigned target;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed strings at the reset settings, decimal and signed.
		set_pace(5, 5);
		@(negedge clk);
		// A character without the first flag while nothing is being parsed is ignored.
		push_char(CH_LOWER_X, 1'b0);
		// Leading whitespace of several kinds and a minus sign.
		push_char(CH_SPACE, 1'b1);
		push_char(8'd9, 1'b0);
		push_char(8'd13, 1'b0);
		push_text("-12");
		push_char(CH_NUL, 1'b0);
		// Plus sign, stopped by the highest character code.
		push_char(CH_PLUS, 1'b1);
		push_text("42");
		push_char(8'hFF, 1'b0);
		// In decimal a 0x prefix is not taken: the zero is a digit and the x stops.
		push_char(CH_ZERO, 1'b1);
		push_char(CH_LOWER_X, 1'b0);
		// A first flag in mid-string drops the open string and starts over.
		push_char("9", 1'b1);
		push_char("9", 1'b0);
		push_char("7", 1'b1);
		push_char(CH_NUL, 1'b0);
		// A sign with no digit after it stays counted, and the value is zero.
		push_char(CH_MINUS, 1'b1);
		push_char(CH_SPACE, 1'b0);
		// An empty string.
		push_char(CH_NUL, 1'b1);

		// Random phases, each with its own register settings and pacing. Every phase ends
		// with an open string that the run after it finishes, so that register writes also
		// land in mid-string: the base must hold and the sign mode must switch at once.
		for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			case (p)
				0: plan_radix = 6'd0;
				1: plan_radix = 6'd16;
				2: plan_radix = 6'd8;
				3: plan_radix = 6'd2;
				4: plan_radix = 6'd36;
				5: plan_radix = 6'd1;
				6: plan_radix = 6'd0;
				7: plan_radix = 6'd63;
				8: plan_radix = 6'd37;
				default: plan_radix = 6'($urandom_range(36));
			endcase
			write_reg(CFG_RADIX, plan_radix);
			write_reg(CFG_UNSIGNED, {5'd0, p[0] ^ (p > 5)});
			set_pace((p % 4 < 2) ? 5 : 0, (p % 2 == 0) ? 5 : 0);
			@(negedge clk);
			if (p != 0) begin
				push_char("5", 1'b0);
				push_char(CH_NUL, 1'b0);
			end
			target = queued_items + PHASE_ITEMS;
			while (queued_items < target) begin
				if ($urandom_range(9) < 8)
					push_number();
				else
					push_noise();
			end
			push_char(CH_MINUS, 1'b1);
			push_char("7", 1'b0);
		end

		// Back to decimal, signed. The receiver holds off for a long stretch while short
		// strings keep coming at full rate, so the block has to stall its input.
		wait_idle();
		write_reg(CFG_RADIX, 6'd10);
		write_reg(CFG_UNSIGNED, 6'd0);
		set_pace(0, 0);
		@(negedge clk);
		push_char("5", 1'b0);
		push_char(CH_NUL, 1'b0);
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		@(negedge clk);
		repeat (60) begin
			push_char(digit_char($urandom_range(9), 1'b0), 1'b1);
			push_char(CH_NUL, 1'b0);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** text_to_integer_parser: PASSED **");
		end else begin
			$display("** text_to_integer_parser: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/ttip_pkg.sv
rtl/text_to_integer_parser.sv
rtl/ttip_checker.sv
tb/text_to_integer_parser_tb.sv
